### rtl/core/lcr_pkg.sv
`default_nettype none

package lcr_pkg;

	// Store depth and coordinate widths.
	localparam int LAMPS = 1024;
	localparam int POS_W = 32;
	localparam int OUT_W = POS_W + 1;

	// Scan controller codes.
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	// Broadcast control for the row of sorting cells.
	typedef struct packed {
		logic             insert;
		logic             shift;
		logic [POS_W-1:0] pos;
	} cell_ctrl_t;

	// Control for the gap scanner at the head of the row.
	typedef struct packed {
		logic load;
		logic step;
	} scan_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/lamp_coverage_radius_unit.sv
`default_nettype none

// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------
// input    | in_valid / in_ready  | position[31:0], last
// output   | out_valid/ out_ready | radius_doubled[32:0]
// config   | cfg_we               | cfg_wdata[31:0] (street_length)
//
// Each position word is placed in the sorted row of cells as it is accepted, and a
// word that arrives at a full row is dropped, so a set streams in at one word per
// cycle. After the last word the row drains into the gap scanner one cell per cycle.
// The input is held off during that scan, and the scan waits at its end while an
// earlier result is still unaccepted. A finished result waits in the output
// register while the next set streams in. Reset empties the row through the
// occupancy flags; positions are not cleared.
module lamp_coverage_radius_unit
	import lcr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [POS_W-1:0] position,
	input  wire logic             last,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [OUT_W-1:0]      radius_doubled,
	input  wire logic             cfg_we,
	input  wire logic [POS_W-1:0] cfg_wdata
);

	logic             state_q;
	logic             first_q;
	logic             out_valid_q;
	logic [OUT_W-1:0] radius_q;
	logic [POS_W-1:0] street_length_q;

	logic             in_acc;
	logic             finish;
	cell_ctrl_t       cell_ctrl;
	scan_ctrl_t       scan_ctrl;
	logic [OUT_W-1:0] scan_result;

	logic             gt_w  [LAMPS];
	logic             occ_w [LAMPS];
	logic [POS_W-1:0] val_w [LAMPS];
	logic [LAMPS-1:0] occ_vec;

	assign in_ready       = (state_q == ST_IDLE);
	assign in_acc         = in_valid && in_ready;
	assign out_valid      = out_valid_q;
	assign radius_doubled = radius_q;

	// Row control: insert unless the row is full, drain during the scan.
	assign cell_ctrl.insert = in_acc && !occ_w[LAMPS-1];
	assign cell_ctrl.shift  = (state_q == ST_SCAN) && (first_q || occ_w[0]);
	assign cell_ctrl.pos    = position;
	assign scan_ctrl.load   = (state_q == ST_SCAN) && first_q;
	assign scan_ctrl.step   = (state_q == ST_SCAN) && !first_q && occ_w[0];
	assign finish           = (state_q == ST_SCAN) && !first_q && !occ_w[0]
		&& (!out_valid_q || out_ready);

	// Row of sorting cells.
	genvar gi;
	generate
		for (gi = 0; gi < LAMPS; gi++) begin : g_cell
			logic             l_gt;
			logic             l_occ;
			logic [POS_W-1:0] l_val;
			logic             r_occ;
			logic [POS_W-1:0] r_val;

			if (gi == 0) begin : g_head
				assign l_gt  = 1'b0;
				assign l_occ = 1'b1;
				assign l_val = '0;
			end else begin : g_body
				assign l_gt  = gt_w[gi-1];
				assign l_occ = occ_w[gi-1];
				assign l_val = val_w[gi-1];
			end

			if (gi == LAMPS - 1) begin : g_tail
				assign r_occ = 1'b0;
				assign r_val = '0;
			end else begin : g_inner
				assign r_occ = occ_w[gi+1];
				assign r_val = val_w[gi+1];
			end

			lcr_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (cell_ctrl),
				.left_gt   (l_gt),
				.left_occ  (l_occ),
				.left_val  (l_val),
				.right_occ (r_occ),
				.right_val (r_val),
				.gt        (gt_w[gi]),
				.occ       (occ_w[gi]),
				.val       (val_w[gi])
			);

			assign occ_vec[gi] = occ_w[gi];
		end
	endgenerate

	// Gap scanner at the head of the row.
	lcr_gap_scan u_scan (
		.clk           (clk),
		.ctrl          (scan_ctrl),
		.head_val      (val_w[0]),
		.street_length (street_length_q),
		.result        (scan_result)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			street_length_q <= '0;
		end else if (cfg_we) begin
			street_length_q <= cfg_wdata;
		end
	end

	// Scan sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			first_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && last) begin
						state_q <= ST_SCAN;
						first_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					first_q <= 1'b0;
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					first_q <= 1'b0;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			radius_q <= scan_result;
		end
	end

	// Occupied cells always form an unbroken run from the head.
	a_occ_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_vec & ~{occ_vec[LAMPS-2:0], 1'b1}) == '0)
		else $error("occupied cell behind an empty one");

	// The two lowest held positions stay in order.
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		occ_w[1] |-> (val_w[0] <= val_w[1]))
		else $error("head of the row out of order");

	// A completed scan leaves the row empty.
	a_row_empty: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (occ_vec == '0))
		else $error("row not empty after scan");

	// A result only appears at the end of a scan.
	a_out_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_SCAN))
		else $error("result without a scan");

endmodule

`default_nettype wire

### rtl/core/lcr_cell.sv
`default_nettype none

module lcr_cell
	import lcr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cell_ctrl_t       ctrl,
	input  wire logic             left_gt,
	input  wire logic             left_occ,
	input  wire logic [POS_W-1:0] left_val,
	input  wire logic             right_occ,
	input  wire logic [POS_W-1:0] right_val,
	output logic                  gt,
	output logic                  occ,
	output logic [POS_W-1:0]      val
);

	logic             occ_q;
	logic [POS_W-1:0] val_q;

	// An empty cell counts as holding a value above any position.
	assign gt  = !occ_q || (val_q > ctrl.pos);
	assign occ = occ_q;
	assign val = val_q;

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.shift) begin
			occ_q <= right_occ;
		end else if (ctrl.insert) begin
			occ_q <= occ_q | left_occ;
		end
	end

	// Stored position: move right past the new word, or take it, or drain left.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			val_q <= right_val;
		end else if (ctrl.insert && gt) begin
			val_q <= left_gt ? left_val : ctrl.pos;
		end
	end

endmodule

`default_nettype wire

### rtl/core/lcr_gap_scan.sv
`default_nettype none

module lcr_gap_scan
	import lcr_pkg::*;
(
	input  wire logic             clk,
	input  wire scan_ctrl_t       ctrl,
	input  wire logic [POS_W-1:0] head_val,
	input  wire logic [POS_W-1:0] street_length,
	output logic [OUT_W-1:0]      result
);

	logic [OUT_W-1:0] best_q;
	logic [POS_W-1:0] prev_q;
	logic [POS_W-1:0] gap;
	logic [OUT_W-1:0] end_term;

	assign gap = head_val - prev_q;

	// Running maximum; the first term is twice the lowest position.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			best_q <= {head_val, 1'b0};
			prev_q <= head_val;
		end else if (ctrl.step) begin
			if ({1'b0, gap} > best_q) begin
				best_q <= {1'b0, gap};
			end
			prev_q <= head_val;
		end
	end

	// The end term uses the highest position, clamped at zero past the street end.
	always_comb begin
		end_term = '0;
		if (street_length > prev_q) begin
			end_term = {street_length - prev_q, 1'b0};
		end
		result = (end_term > best_q) ? end_term : best_q;
	end

endmodule

`default_nettype wire

### tb/lamp_radius_checker.sv
`timescale 1ns / 100ps

module lamp_radius_checker
	import lcr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_ready,
	input  wire logic [POS_W-1:0] position,
	input  wire logic             last,
	input  wire logic             out_valid,
	input  wire logic             out_ready,
	input  wire logic [OUT_W-1:0] radius_doubled,
	input  wire logic             cfg_we,
	input  wire logic [POS_W-1:0] cfg_wdata,
	output int                    mismatches,
	output int                    radii_due,
	output int                    radii_seen
);

	// Lamps of the open set in ascending order, and the radii still owed.
	logic [POS_W-1:0] held_lamps[$];
	logic [OUT_W-1:0] radius_queue[$];
	logic [POS_W-1:0] street_end = '0;
	logic [OUT_W-1:0] want;

	// Place one lamp behind every lamp that is not higher; a full store drops it.
	function automatic void place_lamp(input logic [POS_W-1:0] p);
		int k;
		if (held_lamps.size() >= LAMPS)
			return;
		k = held_lamps.size();
		while (k > 0 && held_lamps[k-1] > p)
			k--;
		held_lamps.insert(k, p);
	endfunction

	// Twice the least radius: widest neighbor gap against both doubled end terms.
	function automatic logic [OUT_W-1:0] doubled_radius();
		logic [OUT_W-1:0] best;
		logic [OUT_W-1:0] term;
		best = '0;
		for (int i = 1; i < held_lamps.size(); i++) begin
			term = OUT_W'(held_lamps[i] - held_lamps[i-1]);
			if (term > best)
				best = term;
		end
		term = {held_lamps[0], 1'b0};
		if (term > best)
			best = term;
		// A lamp at or past the street end leaves no end term.
		if (street_end > held_lamps[$]) begin
			term = {street_end - held_lamps[$], 1'b0};
			if (term > best)
				best = term;
		end
		return best;
	endfunction

	// Follow the register, place each accepted lamp word and predict on the last, compare each result word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_lamps.delete();
			radius_queue.delete();
			street_end = '0;
			mismatches <= 0;
			radii_due <= 0;
			radii_seen <= 0;
		end else begin
			if (cfg_we)
				street_end = cfg_wdata;
			if (out_valid && out_ready) begin
				if (radius_queue.size() == 0) begin
					$error("radius_doubled: no word expected, got %0d", radius_doubled);
					mismatches <= mismatches + 1;
				end else begin
					want = radius_queue.pop_front();
					if (radius_doubled !== want) begin
						$error("radius_doubled: expected %0d, got %0d", want, radius_doubled);
						mismatches <= mismatches + 1;
					end
				end
				radii_seen <= radii_seen + 1;
			end
			if (in_valid && in_ready) begin
				place_lamp(position);
				if (last) begin
					radius_queue.push_back(doubled_radius());
					held_lamps.delete();
				end
			end
			radii_due <= radius_queue.size();
		end
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import lcr_pkg::*;

	localparam int IDLE_PCT = 24;
	localparam int STALL_LIMIT = 20000;
	// Time for a full row of LAMPS cells to drain, with margin on top.
	localparam int SETTLE = LAMPS + 8;

	// How lamp positions are spread over the coordinate range.
	typedef enum int {
		SPREAD_FULL,
		SPREAD_STREET,
		SPREAD_CLUSTER,
		SPREAD_TOP
	} spread_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [POS_W-1:0] position = '0;
	logic             last = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [OUT_W-1:0] radius_doubled;
	logic             cfg_we = 1'b0;
	logic [POS_W-1:0] cfg_wdata = '0;

	int               mismatches;
	int               radii_due;
	int               radii_seen;
	bit               calm = 1'b0;
	int               words_sent = 0;
	int               streets_used = 0;
	int               quiet_cycles = 0;
	logic [POS_W-1:0] street_now = '0;

	always #6 clk = ~clk;

	lamp_coverage_radius_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.position       (position),
		.last           (last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.radius_doubled (radius_doubled),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	lamp_radius_checker radius_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.position       (position),
		.last           (last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.radius_doubled (radius_doubled),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.mismatches     (mismatches),
		.radii_due      (radii_due),
		.radii_seen     (radii_seen)
	);

	// The result side stalls at random except during the calm stretch.
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Give up once no word has moved on either side for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one lamp word, possibly after some idle cycles, and hold it until taken.
	task automatic send_word(input logic [POS_W-1:0] p, input logic is_last);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		position <= p;
		last <= is_last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	// Let every owed radius come out, then give the scan time to finish.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (radii_due != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_street(input logic [POS_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		street_now = v;
		@(posedge clk);
		cfg_we <= 1'b0;
		streets_used++;
	endtask

	function automatic logic [POS_W-1:0] pick_position(input spread_t spread);
		case (spread)
			SPREAD_STREET: begin
				// Mostly inside the street, now and then just past its end.
				if ($urandom_range(0, 7) == 0)
					return street_now + POS_W'($urandom_range(0, 15));
				return POS_W'($urandom_range(0, street_now));
			end
			SPREAD_CLUSTER: return POS_W'($urandom_range(0, 15));
			SPREAD_TOP:     return '1 - POS_W'($urandom_range(0, 15));
			default:        return POS_W'($urandom);
		endcase
	endfunction

	task automatic run_set(input int n, input spread_t spread);
		for (int i = 0; i < n; i++)
			send_word(pick_position(spread), i == n - 1);
	endtask

	// Mostly short sets, some of a few dozen lamps, each with its own spread.
	task automatic random_phase(input int budget);
		int sent;
		int n;
		sent = 0;
		while (sent < budget) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
			run_set(n, spread_t'($urandom_range(SPREAD_FULL, SPREAD_TOP)));
			sent += n;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets on a short street: lone lamps at both coordinate
		// extremes, repeated lamps, a lamp on the street end, unsorted and
		// descending arrival.
		set_street(32'd1000);
		send_word(32'd0, 1'b1);
		send_word('1, 1'b1);
		send_word(32'd500, 1'b0);
		send_word(32'd500, 1'b0);
		send_word(32'd500, 1'b1);
		send_word(32'd900, 1'b0);
		send_word(32'd100, 1'b0);
		send_word(32'd400, 1'b0);
		send_word(32'd300, 1'b0);
		send_word(32'd1000, 1'b1);
		send_word(32'd800, 1'b0);
		send_word(32'd600, 1'b0);
		send_word(32'd400, 1'b0);
		send_word(32'd200, 1'b1);
		settle();

		// A street of zero length: every lamp lies past its end.
		set_street('0);
		send_word(32'd5, 1'b1);
		send_word(32'd7, 1'b0);
		send_word(32'd3, 1'b1);
		settle();

		// The longest street: the end terms and the widest gap reach full width.
		set_street('1);
		send_word(32'd0, 1'b1);
		send_word('1, 1'b0);
		send_word(32'd0, 1'b1);
		send_word(32'h8000_0000, 1'b1);
		settle();

		// Random sets over several street lengths; one phase runs without idling.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0:       set_street(POS_W'($urandom));
				1:       set_street('1);
				2:       set_street(POS_W'($urandom_range(0, 4095)));
				3:       set_street('0);
				default: set_street(POS_W'($urandom));
			endcase
			calm = (ph == 1);
			random_phase(70);
			// Overfill the store once.
			if (ph == 4) begin
				run_set(LAMPS + 6, SPREAD_FULL);
			end
			settle();
			calm = 1'b0;
		end

		$display("Checked %0d radii from %0d lamp words over %0d street lengths,",
			radii_seen, words_sent, streets_used);
		$display("with repeated lamps, lamps past the street end and an overfilled store.");
		if (mismatches == 0 && radii_due == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
